// File: design/euler_to_quaternion_assert.svh
// assertion macros used by the quaternion stage of the conversion pipeline
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define E2Q_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// when pre holds, post must hold at the next clock edge
`define E2Q_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define E2Q_ASSERT_ALWAYS(lbl, cond)
`define E2Q_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: design/e2q_pkg.sv
package e2q_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int OUT_BITS_DEF     = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // cordic datapath widths: q2.30 values and 32-bit half angles with headroom
    localparam int XW = 34;
    localparam int ZW = 33;

    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    // start value: cordic gain compensation in q2.30
    localparam cval_t CORDIC_START = 34'sd652032874;

    // lanes: 0 heading, 1 pitch, 2 bank
    typedef struct packed {
        logic              action;
        logic [2:0][XW-1:0] x;
        logic [2:0][XW-1:0] y;
        logic [2:0][ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_ang(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: design/euler_to_quaternion.sv
// euler angles to unit quaternion
// s_tdata carries heading, pitch and bank as signed binary angles (full range
// spans -pi..pi); s_tuser is the direction: 1 inertial-to-object, 0 the reverse.
// m_tdata carries qw, qx, qy, qz as saturated signed q1.(OUT_BITS-1) values.
// each angle is halved and turned into sine and cosine by a row of
// CORDIC_STEPS cordic cells, one rotation per cell, all three angles side by side,
// followed by four stages: pair products, triple products, sums, round/saturate.
// throughput: one beat per cycle while the receiver takes beats; every stage is one register.
// reset clears all stage valid flags; the pipeline is empty afterwards.
// when the receiver stalls, the output register holds its beat and the stages
// behind it fill up, so bubbles close; s_tready drops only when every stage
// holds a beat.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int OUT_BITS     = OUT_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // heading, pitch, bank, zero fill
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]     s_tdata,
    // action
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // qw, qx, qy, qz, zero fill
    output logic [((4*OUT_BITS+7)/8)*8-1:0]       m_tdata
);

    localparam int OW = ((4*OUT_BITS+7)/8)*8;

    logic signed [ANGLE_BITS-1:0] ang [3];
    logic signed [31:0]           a32 [3];
    cordic_t                      seed;

    logic    c_valid [CORDIC_STEPS+1];
    logic    c_ready [CORDIC_STEPS+1];
    cordic_t c_data  [CORDIC_STEPS+1];

    logic signed [OUT_BITS-1:0] qw, qx, qy, qz;

    // align each angle to 32 bits and halve it
    always_comb
    begin
        seed.action = s_tuser;
        for (int i = 0; i < 3; i++)
        begin
            ang[i]    = $signed(s_tdata[i*ANGLE_BITS +: ANGLE_BITS]);
            a32[i]    = 32'(ang[i]) <<< (32 - ANGLE_BITS);
            seed.x[i] = CORDIC_START;
            seed.y[i] = '0;
            seed.z[i] = zval_t'(a32[i] >>> 1);
        end
    end

    assign c_valid[0] = s_tvalid;
    assign c_data[0]  = seed;
    assign s_tready   = c_ready[0];

    // row of rotation cells
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        e2q_cordic_cell #(
            .STEP(k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (c_valid[k]),
            .in_ready (c_ready[k]),
            .in_data  (c_data[k]),
            .out_valid(c_valid[k+1]),
            .out_ready(c_ready[k+1]),
            .out_data (c_data[k+1])
        );
    end

    e2q_quat #(
        .OUT_BITS(OUT_BITS)
    ) u_quat (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid[CORDIC_STEPS]),
        .in_ready (c_ready[CORDIC_STEPS]),
        .in_data  (c_data[CORDIC_STEPS]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .qw       (qw),
        .qx       (qx),
        .qy       (qy),
        .qz       (qz)
    );

    assign m_tdata = OW'({qz, qy, qx, qw});

endmodule

// File: design/e2q_cordic_cell.sv
module e2q_cordic_cell
    import e2q_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    localparam zval_t ATAN = zval_t'({1'b0, atan_ang(STEP)});

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // stage moves when empty or when the next cell takes its beat
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one rotation step on each of the three lanes
    always_comb
    begin
        cval_t xi;
        cval_t yi;
        zval_t zi;
        data_next        = in_data;
        for (int i = 0; i < 3; i++)
        begin
            xi = $signed(in_data.x[i]);
            yi = $signed(in_data.y[i]);
            zi = $signed(in_data.z[i]);
            if (!zi[ZW-1])
            begin
                data_next.x[i] = xi - (yi >>> STEP);
                data_next.y[i] = yi + (xi >>> STEP);
                data_next.z[i] = zi - ATAN;
            end
            else
            begin
                data_next.x[i] = xi + (yi >>> STEP);
                data_next.y[i] = yi - (xi >>> STEP);
                data_next.z[i] = zi + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/e2q_quat.sv
`include "euler_to_quaternion_assert.svh"

module e2q_quat
    import e2q_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cordic_t                    in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_BITS-1:0] qw,
    output logic signed [OUT_BITS-1:0] qx,
    output logic signed [OUT_BITS-1:0] qy,
    output logic signed [OUT_BITS-1:0] qz
);

    localparam int SH = 60 - (OUT_BITS - 1);
    localparam logic signed [65:0] RND = 66'sd1 <<< (SH - 1);
    localparam logic signed [65:0] HI  = (66'sd1 <<< (OUT_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] LO  = -HI - 66'sd1;

    logic [3:0] v_reg;
    logic [3:0] en;

    // stage 1: pair products rounded back to q2.30
    logic signed [31:0] chcp_reg, shsp_reg, chsp_reg, shcp_reg, sb_reg, cb_reg;
    logic               act1_reg;
    // stage 2: triple products in q60
    logic signed [63:0] t_reg [8];
    logic               act2_reg;
    // stage 3: component sums
    logic signed [65:0] w_reg, x_reg, y_reg, z_reg;
    // stage 4: output register
    logic signed [OUT_BITS-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic signed [31:0] sh, ch, sp, cp, sb, cb;

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] rnd_sat(input logic signed [65:0] q);
        logic signed [65:0] v;
        v = (q + RND) >>> SH;
        if (v > HI)
        begin
            v = HI;
        end
        else if (v < LO)
        begin
            v = LO;
        end
        return v[OUT_BITS-1:0];
    endfunction

    // stall chain: a stage advances when empty or when its successor advances
    assign en[3] = !v_reg[3] || out_ready;
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];

    assign in_ready  = en[0];
    assign out_valid = v_reg[3];
    assign qw        = qw_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign qz        = qz_reg;

    // sine and cosine of each half angle, trimmed to 32 bits
    assign sh = $signed(in_data.y[0][31:0]);
    assign ch = $signed(in_data.x[0][31:0]);
    assign sp = $signed(in_data.y[1][31:0]);
    assign cp = $signed(in_data.x[1][31:0]);
    assign sb = $signed(in_data.y[2][31:0]);
    assign cb = $signed(in_data.x[2][31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    // pair products
    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            chcp_reg <= mul_q30(ch, cp);
            shsp_reg <= mul_q30(sh, sp);
            chsp_reg <= mul_q30(ch, sp);
            shcp_reg <= mul_q30(sh, cp);
            sb_reg   <= sb;
            cb_reg   <= cb;
            act1_reg <= in_data.action;
        end
    end

    // triple products
    always_ff @(posedge clk)
    begin
        if (en[1] && v_reg[0])
        begin
            t_reg[0] <= 64'(chcp_reg) * 64'(cb_reg);
            t_reg[1] <= 64'(shsp_reg) * 64'(sb_reg);
            t_reg[2] <= 64'(chsp_reg) * 64'(cb_reg);
            t_reg[3] <= 64'(shcp_reg) * 64'(sb_reg);
            t_reg[4] <= 64'(chsp_reg) * 64'(sb_reg);
            t_reg[5] <= 64'(shcp_reg) * 64'(cb_reg);
            t_reg[6] <= 64'(shsp_reg) * 64'(cb_reg);
            t_reg[7] <= 64'(chcp_reg) * 64'(sb_reg);
            act2_reg <= act1_reg;
        end
    end

    // sums, vector part negated for the object-to-inertial direction
    always_ff @(posedge clk)
    begin
        if (en[2] && v_reg[1])
        begin
            w_reg <= 66'(t_reg[0]) + 66'(t_reg[1]);
            if (act2_reg)
            begin
                x_reg <= 66'(t_reg[2]) + 66'(t_reg[3]);
                y_reg <= 66'(t_reg[5]) - 66'(t_reg[4]);
                z_reg <= 66'(t_reg[7]) - 66'(t_reg[6]);
            end
            else
            begin
                x_reg <= -66'(t_reg[2]) - 66'(t_reg[3]);
                y_reg <= 66'(t_reg[4]) - 66'(t_reg[5]);
                z_reg <= 66'(t_reg[6]) - 66'(t_reg[7]);
            end
        end
    end

    // round and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (en[3] && v_reg[2])
        begin
            qw_reg <= rnd_sat(w_reg);
            qx_reg <= rnd_sat(x_reg);
            qy_reg <= rnd_sat(y_reg);
            qz_reg <= rnd_sat(z_reg);
        end
    end

    `E2Q_ASSERT_ALWAYS(a_stall_only_full, in_ready || (&v_reg))
    `E2Q_ASSERT_NEXT(a_take_fills_first, in_valid && in_ready, v_reg[0])
    `E2Q_ASSERT_NEXT(a_out_leaves_on_take, out_valid && !out_ready, out_valid)

endmodule
